// ===== hdl/array_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array priority queue
// Shared property shorthands, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Check cons in the same cycle as ante
`define APQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("array_priority_queue: same-cycle check failed");

// Check cons in the cycle after ante
`define APQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("array_priority_queue: next-cycle check failed");

`endif

// ===== hdl/apq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue package
// Shared codes, controller states and the structs passed between cells.
// ----------------------------------------------------------------------------
package apq_pkg;

	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;
	localparam int CAP_W  = 5;
	localparam int STAT_W = 2;

	// Command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// Status codes
	localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_REMOVE
	} state_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_op_t;

	// Best entry so far, handed down the chain
	typedef struct packed {
		logic                     valid;
		logic signed [PRIO_W-1:0] prio;
		logic signed [DATA_W-1:0] data;
	} carry_t;

	// Result word control from the controller
	typedef struct packed {
		logic              strobe;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

// ===== hdl/apq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue cell
// Holds one entry, takes an appended word or its upper neighbour's entry, and
// runs one stage of the best-priority search chain.
// ----------------------------------------------------------------------------
module apq_cell
	import apq_pkg::*;
#(
	parameter int IDX_W = 4,
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_op_t                 op,
	input  logic [CNT_W-1:0]         count,
	input  logic [IDX_W-1:0]         best_idx,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic signed [PRIO_W-1:0] wr_prio,
	input  logic signed [DATA_W-1:0] nxt_data,
	input  logic signed [PRIO_W-1:0] nxt_prio,
	input  carry_t                   carry_in,
	input  logic [IDX_W-1:0]         idx_in,
	output carry_t                   carry_out,
	output logic [IDX_W-1:0]         idx_out,
	output logic signed [DATA_W-1:0] data,
	output logic signed [PRIO_W-1:0] prio
);

	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [PRIO_W-1:0] prio_q;
	carry_t                   carry_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     own_valid;
	logic                     own_wins;

	// Store: append at the tail, or close the gap above the removed entry
	always_ff @(posedge clk) begin
		if (op.load && (count == MY_CNT)) begin
			data_q <= wr_data;
			prio_q <= wr_prio;
		end else if (op.shift && (MY_IDX >= best_idx)) begin
			data_q <= nxt_data;
			prio_q <= nxt_prio;
		end
	end

	// Own entry replaces the carry when the carry is empty or on a strictly greater priority
	assign own_valid = (MY_CNT < count);
	assign own_wins  = own_valid && (!carry_in.valid || ($signed(prio_q) > $signed(carry_in.prio)));

	// Search stage: advance the best entry one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			idx_q   <= '0;
		end else if (own_wins) begin
			carry_q.valid <= 1'b1;
			carry_q.prio  <= prio_q;
			carry_q.data  <= data_q;
			idx_q         <= MY_IDX;
		end else begin
			carry_q <= carry_in;
			idx_q   <= idx_in;
		end
	end

	assign carry_out = carry_q;
	assign idx_out   = idx_q;
	assign data      = data_q;
	assign prio      = prio_q;

endmodule

// ===== hdl/apq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue controller
// Sequences appends, the search pass and the removal, and keeps the count.
// ----------------------------------------------------------------------------
module apq_ctrl
	import apq_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int IDX_W       = 4,
	parameter int CNT_W       = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cmd,
	input  logic             full,
	output logic             busy,
	output cell_op_t         op,
	output logic [CNT_W-1:0] count,
	output res_t             res
);

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ENTRIES - 1);

	state_t           state_q;
	state_t           state_nxt;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] count_q;
	res_t             res_q;
	logic             accept;
	logic             empty;

	assign accept = start && (state_q == S_IDLE);
	assign empty  = (count_q == '0);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (cmd == CMD_DEQ) && !empty) begin
					state_nxt = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (step_q == LAST_STEP) begin
					state_nxt = S_REMOVE;
				end
			end
			S_REMOVE: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		busy     = 1'b1;
		op.load  = 1'b0;
		op.shift = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy    = 1'b0;
				op.load = accept && (cmd == CMD_ENQ) && !full;
			end
			S_SEARCH: begin
				busy = 1'b1;
			end
			S_REMOVE: begin
				op.shift = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// State, search step and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_SEARCH) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (op.load) begin
				count_q <= count_q + 1'b1;
			end else if (op.shift) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result strobe and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (op.shift) begin
			res_q.strobe <= 1'b1;
			res_q.status <= STATUS_DONE;
		end else if (accept && (cmd == CMD_ENQ)) begin
			res_q.strobe <= 1'b1;
			res_q.status <= full ? STATUS_FULL : STATUS_DONE;
		end else if (accept && empty) begin
			res_q.strobe <= 1'b1;
			res_q.status <= STATUS_EMPTY;
		end else begin
			res_q.strobe <= 1'b0;
			res_q.status <= STATUS_DONE;
		end
	end

	assign count = count_q;
	assign res   = res_q;

endmodule

// ===== hdl/array_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue
// Unsorted priority queue in a row of cells: appends at the tail, removes the
// highest signed priority (earliest on a tie) and closes the gap.
// ----------------------------------------------------------------------------
//  channel   | handshake          | words
//  ----------+--------------------+------------------------------------------
//  command   | start / busy       | cmd, item_data, item_priority
//  result    | done (strobe)      | status, out_data, out_priority, entry_count
//  config    | cfg_wr_en          | cfg_wr_data (capacity in use)
//
// Enqueue and empty dequeue: result in the cycle after start, busy stays low.
// Dequeue: busy through the search pass and the removal step; the result is
// registered on removal. The search chain advances one cell per cycle.
// Reset: count zero, capacity 16; entries hold nothing valid until written.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`include "array_priority_queue_macros.svh"

module array_priority_queue
	import apq_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cmd,
	input  logic signed [DATA_W-1:0] item_data,
	input  logic signed [PRIO_W-1:0] item_priority,
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         cfg_wr_data,
	output logic                     done,
	output logic [STAT_W-1:0]        status,
	output logic signed [DATA_W-1:0] out_data,
	output logic signed [PRIO_W-1:0] out_priority,
	output logic [CAP_W-1:0]         entry_count
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	logic [CAP_W-1:0]         capacity_q;
	logic [CNT_W-1:0]         count;
	logic [CMP_W-1:0]         count_ext;
	logic [CMP_W-1:0]         cap_ext;
	logic                     full;
	cell_op_t                 op;
	res_t                     res;
	logic signed [DATA_W-1:0] out_data_q;
	logic signed [PRIO_W-1:0] out_prio_q;

	carry_t                   chain     [MAX_ENTRIES+1];
	logic [IDX_W-1:0]         chain_idx [MAX_ENTRIES+1];
	logic signed [DATA_W-1:0] cell_data [MAX_ENTRIES];
	logic signed [PRIO_W-1:0] cell_prio [MAX_ENTRIES];
	logic signed [DATA_W-1:0] nxt_data  [MAX_ENTRIES];
	logic signed [PRIO_W-1:0] nxt_prio  [MAX_ENTRIES];

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// Full at the configured capacity or at the array size
	assign count_ext   = CMP_W'(count);
	assign cap_ext     = CMP_W'(capacity_q);
	assign full        = (count_ext >= cap_ext) || (count == CNT_W'(MAX_ENTRIES));
	assign entry_count = count_ext[CAP_W-1:0];

	apq_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.full  (full),
		.busy  (busy),
		.op    (op),
		.count (count),
		.res   (res)
	);

	// Head of the search chain holds nothing
	assign chain[0]     = '0;
	assign chain_idx[0] = '0;

	// Row of cells
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		if (g == MAX_ENTRIES - 1) begin : g_last
			assign nxt_data[g] = cell_data[g];
			assign nxt_prio[g] = cell_prio[g];
		end else begin : g_mid
			assign nxt_data[g] = cell_data[g+1];
			assign nxt_prio[g] = cell_prio[g+1];
		end

		apq_cell #(
			.IDX_W(IDX_W),
			.CNT_W(CNT_W),
			.INDEX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.count    (count),
			.best_idx (chain_idx[MAX_ENTRIES]),
			.wr_data  (item_data),
			.wr_prio  (item_priority),
			.nxt_data (nxt_data[g]),
			.nxt_prio (nxt_prio[g]),
			.carry_in (chain[g]),
			.idx_in   (chain_idx[g]),
			.carry_out(chain[g+1]),
			.idx_out  (chain_idx[g+1]),
			.data     (cell_data[g]),
			.prio     (cell_prio[g])
		);
	end

	// Result word: the winner on removal, cleared when a command is accepted, held otherwise
	always_ff @(posedge clk) begin
		if (op.shift) begin
			out_data_q <= chain[MAX_ENTRIES].data;
			out_prio_q <= chain[MAX_ENTRIES].prio;
		end else if (start && !busy) begin
			out_data_q <= '0;
			out_prio_q <= '0;
		end
	end

	assign done         = res.strobe;
	assign status       = res.status;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;

	`APQ_ASSERT_SAME(a_remove_has_winner, op.shift, chain[MAX_ENTRIES].valid)
	`APQ_ASSERT_NEXT(a_deq_goes_busy, start && !busy && (cmd == CMD_DEQ) && (count != '0), busy)
	`APQ_ASSERT_SAME(a_empty_count_zero, done && (status == STATUS_EMPTY), entry_count == '0)
	`APQ_ASSERT_SAME(a_fail_word_zero, done && (status != STATUS_DONE), (out_data == '0) && (out_priority == '0))

endmodule
